@@ src/rplc_pkg.sv @@
// Shared types, codes and reset constants for the rotary pin lock controller.
package rplc_pkg;

    localparam int DIGITS_DEFAULT = 3;
    localparam int DIGITS_MAX     = 8;

    localparam int NIBBLE_W   = 4;
    localparam int CODE_W     = 32;
    localparam int ATTEMPTS_W = 8;
    localparam int POS_W      = 4;
    localparam int MODE_W     = 2;
    localparam int EVENT_W    = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CODE_W-1:0]     SECRET_CODE_RESET  = 32'd546;
    localparam logic [ATTEMPTS_W-1:0] MAX_ATTEMPTS_RESET = 8'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SECRET_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd1;

    // Lock mode codes as seen on the result port.
    localparam logic [MODE_W-1:0] LOCK_MODE_ENTERING = 2'd0;
    localparam logic [MODE_W-1:0] LOCK_MODE_GRANTED  = 2'd1;
    localparam logic [MODE_W-1:0] LOCK_MODE_LOCKED   = 2'd2;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_IGNORED = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ADVANCE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_NEXT    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SUCCESS = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RETRY   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ALARM   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_DIRSET  = 3'd6;

    localparam logic [NIBBLE_W-1:0] DIGIT_LAST = 4'd9;

    typedef enum logic [2:0] {
        MODE_ENTERING = 3'b001,
        MODE_GRANTED  = 3'b010,
        MODE_LOCKED   = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        mode_t                 mode;
        dir_t                  dir;
        logic [NIBBLE_W-1:0]   digit;
        logic [POS_W-1:0]      position;
        logic [ATTEMPTS_W-1:0] attempts;
    } lock_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]     lock_mode;
        logic [NIBBLE_W-1:0]   shown_digit;
        logic [POS_W-1:0]      digit_position;
        logic [ATTEMPTS_W-1:0] attempts_left;
        logic [EVENT_W-1:0]    event_code;
    } result_t;

endpackage

@@ src/rplc_step.sv @@
// Next-state and result logic for one encoder step or button press.
module rplc_step #(
    parameter int DIGITS = rplc_pkg::DIGITS_DEFAULT
) (
    input  rplc_pkg::lock_state_t            cur,
    input  logic [rplc_pkg::NIBBLE_W*DIGITS-1:0] entered,
    input  logic [rplc_pkg::CODE_W-1:0]      secret_code,
    input  logic                             command,
    input  logic                             turn_ccw,
    output rplc_pkg::lock_state_t            nxt,
    output logic [rplc_pkg::NIBBLE_W*DIGITS-1:0] entered_next,
    output rplc_pkg::result_t                result
);

    localparam logic [rplc_pkg::POS_W-1:0] LAST_POS = rplc_pkg::POS_W'(DIGITS);

    rplc_pkg::dir_t                    step_dir;
    logic                              fail;
    logic                              match;
    logic [rplc_pkg::POS_W-1:0]        pos_inc;
    logic [rplc_pkg::ATTEMPTS_W-1:0]   att_dec;
    logic [rplc_pkg::EVENT_W-1:0]      ev;

    assign step_dir = turn_ccw ? rplc_pkg::DIR_CCW : rplc_pkg::DIR_CW;
    assign pos_inc  = cur.position + 1'b1;
    assign att_dec  = cur.attempts - 1'b1;

    always_comb
    begin
        nxt          = cur;
        entered_next = entered;
        ev           = rplc_pkg::EV_IGNORED;
        fail         = 1'b0;
        match        = 1'b1;

        if (cur.mode == rplc_pkg::MODE_ENTERING)
        begin
            if (command)
            begin
                fail = 1'b1;
            end
            else if (cur.dir == rplc_pkg::DIR_NONE || cur.dir == step_dir)
            begin
                ev = (cur.dir == rplc_pkg::DIR_NONE) ? rplc_pkg::EV_DIRSET
                                                     : rplc_pkg::EV_ADVANCE;
                nxt.dir   = step_dir;
                nxt.digit = (cur.digit == rplc_pkg::DIGIT_LAST) ? '0 : cur.digit + 1'b1;
            end
            else if (cur.position < LAST_POS)
            begin
                // A reversal stores the shown digit in the current slot.
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (cur.position == rplc_pkg::POS_W'(i))
                    begin
                        entered_next[i*rplc_pkg::NIBBLE_W +: rplc_pkg::NIBBLE_W] = cur.digit;
                    end
                end
                nxt.position = pos_inc;

                if (pos_inc == LAST_POS)
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if (entered_next[i*rplc_pkg::NIBBLE_W +: rplc_pkg::NIBBLE_W] !=
                            secret_code[i*rplc_pkg::NIBBLE_W +: rplc_pkg::NIBBLE_W])
                        begin
                            match = 1'b0;
                        end
                    end
                    if (match)
                    begin
                        nxt.mode = rplc_pkg::MODE_GRANTED;
                        ev       = rplc_pkg::EV_SUCCESS;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else
                begin
                    nxt.dir   = step_dir;
                    nxt.digit = '0;
                    ev        = rplc_pkg::EV_NEXT;
                end
            end
        end

        if (fail)
        begin
            if (cur.attempts == '0 || att_dec == '0)
            begin
                // Out of attempts: lock, keeping the last digit and position.
                nxt.mode     = rplc_pkg::MODE_LOCKED;
                nxt.attempts = (cur.attempts == '0) ? '0 : att_dec;
                ev           = rplc_pkg::EV_ALARM;
            end
            else
            begin
                nxt.attempts = att_dec;
                nxt.digit    = '0;
                nxt.position = '0;
                nxt.dir      = rplc_pkg::DIR_NONE;
                entered_next = '0;
                ev           = rplc_pkg::EV_RETRY;
            end
        end
    end

    always_comb
    begin
        unique case (nxt.mode)
            rplc_pkg::MODE_ENTERING: result.lock_mode = rplc_pkg::LOCK_MODE_ENTERING;
            rplc_pkg::MODE_GRANTED:  result.lock_mode = rplc_pkg::LOCK_MODE_GRANTED;
            rplc_pkg::MODE_LOCKED:   result.lock_mode = rplc_pkg::LOCK_MODE_LOCKED;
            default:                 result.lock_mode = rplc_pkg::LOCK_MODE_ENTERING;
        endcase
        result.shown_digit    = nxt.digit;
        result.digit_position = nxt.position;
        result.attempts_left  = nxt.attempts;
        result.event_code     = ev;
    end

endmodule

@@ src/rotary_pin_lock_controller.sv @@
// Rotary pin lock controller: lock state, configuration registers and result buffering.
// Results go to the output register, or to the skid stage on a stall. Throughput: one
// item per cycle while in_stall is low; the next-state logic is a single pass from the
// lock state registers to the result register, with a one-entry skid stage behind it.
// Reset: rst_n clears the lock to entering with no digits, loads secret code 546
// and three attempts, and empties the result register and skid stage.
module rotary_pin_lock_controller #(
    parameter int DIGITS = rplc_pkg::DIGITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rplc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rplc_pkg::CODE_W-1:0]        cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic                               turn_ccw,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rplc_pkg::MODE_W-1:0]        lock_mode,
    output logic [rplc_pkg::NIBBLE_W-1:0]      shown_digit,
    output logic [rplc_pkg::POS_W-1:0]         digit_position,
    output logic [rplc_pkg::ATTEMPTS_W-1:0]    attempts_left,
    output logic [rplc_pkg::EVENT_W-1:0]       event_code
);

    localparam int ENT_W = rplc_pkg::NIBBLE_W * DIGITS;

    logic [rplc_pkg::CODE_W-1:0]       secret_code_reg;
    rplc_pkg::lock_state_t             state_reg;
    rplc_pkg::lock_state_t             state_next;
    logic [ENT_W-1:0]                  entered_reg;
    logic [ENT_W-1:0]                  entered_next;
    rplc_pkg::result_t                 step_result;

    rplc_pkg::result_t                 out_data_reg;
    rplc_pkg::result_t                 out_data_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    rplc_pkg::result_t                 skid_data_reg;
    logic                              skid_valid_reg;
    logic                              skid_valid_next;

    logic                              cfg_write;
    logic                              in_accept;
    logic                              out_load;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    // The output register can take a new beat when it is empty or being drained.
    assign out_load  = !out_valid_reg || !out_stall;

    rplc_step #(
        .DIGITS(DIGITS)
    ) u_step (
        .cur          (state_reg),
        .entered      (entered_reg),
        .secret_code  (secret_code_reg),
        .command      (command),
        .turn_ccw     (turn_ccw),
        .nxt          (state_next),
        .entered_next (entered_next),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_code_reg    <= rplc_pkg::SECRET_CODE_RESET;
            state_reg.mode     <= rplc_pkg::MODE_ENTERING;
            state_reg.dir      <= rplc_pkg::DIR_NONE;
            state_reg.digit    <= '0;
            state_reg.position <= '0;
            state_reg.attempts <= rplc_pkg::MAX_ATTEMPTS_RESET;
            entered_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rplc_pkg::CFG_SECRET_CODE:
                begin
                    secret_code_reg <= cfg_data;
                end
                rplc_pkg::CFG_MAX_ATTEMPTS:
                begin
                    state_reg.attempts <= cfg_data[rplc_pkg::ATTEMPTS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            state_reg   <= state_next;
            entered_reg <= entered_next;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load)
        begin
            out_valid_next  = skid_valid_reg || in_accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : step_result;
            skid_valid_next = 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (!out_load && in_accept)
        begin
            skid_data_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lock_mode      = out_data_reg.lock_mode;
    assign shown_digit    = out_data_reg.shown_digit;
    assign digit_position = out_data_reg.digit_position;
    assign attempts_left  = out_data_reg.attempts_left;
    assign event_code     = out_data_reg.event_code;

endmodule
